// ----- hdl/rcmmm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rcmmm_pkg
// shared widths, codes and interface types of the min/max/mean block
// ---------------------------------------------------------------------------
package rcmmm_pkg;

	// sizing
	localparam int MAX_READINGS = 1024;
	localparam int DATA_W       = 12;
	localparam int CNT_W        = 11;
	localparam int SUM_W        = 23;
	localparam int MAG_W        = SUM_W - 1;
	localparam int DIV_STEPS    = MAG_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 2;

	// status codes
	localparam logic [1:0] STAT_ACCEPT = 2'd0;
	localparam logic [1:0] STAT_RANGE  = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd2;

	// reset values
	localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = -12'sd500;
	localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 12'sd600;
	localparam logic [CNT_W-1:0]         CAPACITY_RST   = 11'd1024;

	typedef struct packed {
		logic start;
		logic neg;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage
`default_nettype wire

// ----- hdl/rcmmm_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rcmmm_div
// restoring bit-serial divider, one quotient bit per cycle, signed result
// ---------------------------------------------------------------------------
module rcmmm_div import rcmmm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire div_ctl_t                 ctl,
	input  wire logic [MAG_W-1:0]         dividend,
	input  wire logic [CNT_W-1:0]         divisor,
	output div_sts_t                      sts,
	output logic signed [DATA_W-1:0]      quotient
);

	logic [CNT_W-1:0]  rem_q;
	logic [MAG_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;

	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_nx;

	assign rem_sh = {rem_q, dvd_q[MAG_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			neg_q <= ctl.neg;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops
			rem_q <= rem_nx[CNT_W-1:0];
			dvd_q <= {dvd_q[MAG_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = neg_q ? -$signed(dvd_q[DATA_W-1:0]) : $signed(dvd_q[DATA_W-1:0]);

endmodule
`default_nettype wire

// ----- hdl/range_checked_min_max_mean.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// range_checked_min_max_mean
// running count, mean, maximum and minimum of range-checked temperature words
// ---------------------------------------------------------------------------
// One input word carries a signed sample in tenths of a degree. It is checked
// against low_limit/high_limit (out of range gives status 1, checked first),
// then against the capacity, clipped to MAX_READINGS (full gives status 2);
// otherwise it is taken into the count, running sum, maximum and minimum
// (status 0). Every word returns one result word with the status and the
// statistics after it; the average is sum / count truncated toward zero, and
// all three statistics read zero while the count is zero. A word goes through
// these steps from one accept to the next: check and update, start the
// divider, the bit-serial divide (one quotient bit per cycle over the 22-bit
// sum magnitude), the divider's done flag, and the load of the output
// register, which waits while the register still holds an untaken result.
// With an empty log the divider is skipped. in_ready is high only while the
// sequencer is idle. The output register holds a finished result until taken,
// so the next word can enter meanwhile; a second result waits in the sequencer
// until the register frees up. Configuration writes are always taken
// (cfg_ready tied high); index 3 is ignored.
// ---------------------------------------------------------------------------
module range_checked_min_max_mean import rcmmm_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input words
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [DATA_W-1:0]    sample,
	// result words
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [CNT_W-1:0]                 sample_count,
	output logic signed [DATA_W-1:0]         average,
	output logic signed [DATA_W-1:0]         maximum,
	output logic signed [DATA_W-1:0]         minimum,
	// configuration writes
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CNT_W:0]              cfg_data
);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic signed [DATA_W-1:0] low_q;
	logic signed [DATA_W-1:0] high_q;
	logic [CNT_W-1:0]         cap_q;

	// running statistics
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] min_q;

	// per-word working registers
	logic [1:0]               stat_q;
	logic signed [DATA_W-1:0] avg_q;

	// output register
	logic                     out_valid_q;
	logic [1:0]               out_stat_q;
	logic [CNT_W-1:0]         out_cnt_q;
	logic signed [DATA_W-1:0] out_avg_q;
	logic signed [DATA_W-1:0] out_max_q;
	logic signed [DATA_W-1:0] out_min_q;

	logic                     in_acc;
	logic                     in_range;
	logic [CNT_W-1:0]         eff_cap;
	logic                     log_full;
	logic [1:0]               stat_nx;
	logic                     out_load;
	logic [SUM_W-1:0]         sum_abs;

	div_ctl_t                 div_ctl;
	div_sts_t                 div_sts;
	logic signed [DATA_W-1:0] div_quot;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;

	// range first, then capacity clipped to the storage limit
	assign in_range = (sample >= low_q) && (sample <= high_q);
	assign eff_cap  = (cap_q > CNT_W'(MAX_READINGS)) ? CNT_W'(MAX_READINGS) : cap_q;
	assign log_full = count_q >= eff_cap;

	always_comb begin
		if (!in_range) begin
			stat_nx = STAT_RANGE;
		end else if (log_full) begin
			stat_nx = STAT_FULL;
		end else begin
			stat_nx = STAT_ACCEPT;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_LIMIT_RST;
			high_q <= HIGH_LIMIT_RST;
			cap_q  <= CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOW_LIMIT:  low_q  <= $signed(cfg_data[DATA_W-1:0]);
				REG_HIGH_LIMIT: high_q <= $signed(cfg_data[DATA_W-1:0]);
				REG_CAPACITY:   cap_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// statistics update on an accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '0;
		end else if (in_acc && stat_nx == STAT_ACCEPT) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + {{(SUM_W-DATA_W){sample[DATA_W-1]}}, sample};
			// first sample seeds both extremes
			if (count_q == '0) begin
				max_q <= sample;
				min_q <= sample;
			end else begin
				if (sample > max_q) begin
					max_q <= sample;
				end
				if (sample < min_q) begin
					min_q <= sample;
				end
			end
		end
	end

	// divider is fed the magnitude of the sum; the sign is put back afterwards
	assign sum_abs       = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign div_ctl.start = (state_q == S_START) && (count_q != '0);
	assign div_ctl.neg   = sum_q[SUM_W-1];

	rcmmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (sum_abs[MAG_W-1:0]),
		.divisor  (count_q),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// output register may still hold an untaken result
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					// empty log skips the divide
					state_q <= (count_q == '0) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			stat_q <= stat_nx;
		end
		if (state_q == S_START) begin
			avg_q <= '0;
		end else if (state_q == S_DIV && div_sts.done) begin
			avg_q <= div_quot;
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stat_q <= stat_q;
			out_cnt_q  <= count_q;
			out_avg_q  <= avg_q;
			out_max_q  <= max_q;
			out_min_q  <= min_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_stat_q;
	assign sample_count = out_cnt_q;
	assign average      = out_avg_q;
	assign maximum      = out_max_q;
	assign minimum      = out_min_q;

endmodule
`default_nettype wire

// ----- hdl/rcmmm_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rcmmm_checker
// port-level checks of the min/max/mean block, bound to the top level
// ---------------------------------------------------------------------------
module rcmmm_checker import rcmmm_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [1:0]               status,
	input wire logic [CNT_W-1:0]         sample_count,
	input wire logic signed [DATA_W-1:0] average,
	input wire logic signed [DATA_W-1:0] maximum,
	input wire logic signed [DATA_W-1:0] minimum
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(sample_count) && $stable(average))
		else $error("result word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while busy");

	// an accepted sample leaves a nonempty log
	a_acc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_ACCEPT |-> sample_count != '0)
		else $error("accepted sample with zero count");

	// empty log reads zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count == '0 |-> average == '0 && maximum == '0
			&& minimum == '0)
		else $error("nonzero statistics on empty log");

	// extremes bracket the mean
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> minimum <= average && average <= maximum)
		else $error("mean outside minimum and maximum");

endmodule

bind range_checked_min_max_mean rcmmm_checker u_rcmmm_checker (.*);
`default_nettype wire
